@@ rtl/mrrp_pkg.sv @@
package mrrp_pkg;

    // CRC-16/MODBUS constants
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam int unsigned CRC_BITS = 8;

    // Frame layout: slave, function, count, data, crc low, crc high
    localparam logic [8:0] HEADER_LEN = 9'd3;
    localparam logic [9:0] LAST_OFFSET = 10'd4;
    localparam logic [8:0] COUNT_POS = 9'd2;
    localparam logic [8:0] POS_MAX = 9'd511;

    // Result kinds
    localparam logic KIND_VALUE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Frame status codes
    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_LENGTH = 2'd1;
    localparam logic [1:0] STATUS_CRC = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [15:0] reg_value;
        logic [6:0]  value_index;
        logic [1:0]  frame_status;
    } result_t;

endpackage

@@ rtl/mrrp_if.sv @@
interface mrrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mrrp_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] reg_value;
    logic [6:0]  value_index;
    logic [1:0]  frame_status;

    modport source (output valid, output kind, output reg_value, output value_index,
                    output frame_status, input ready);
    modport sink (input valid, input kind, input reg_value, input value_index,
                  input frame_status, output ready);
endinterface

@@ rtl/mrrp_crc_byte.sv @@
module mrrp_crc_byte
(
    input  logic [15:0] crc,
    input  logic [7:0]  data,
    output logic [15:0] crc_next
);
    import mrrp_pkg::*;

    // Fold one byte in, eight reflected shift steps
    always_comb
    begin
        logic [15:0] c;
        c = crc ^ {8'd0, data};
        for (int i = 0; i < CRC_BITS; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_next = c;
    end
endmodule

@@ rtl/mrrp_frame_tracker.sv @@
module mrrp_frame_tracker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  logic              frame_end,
    output logic              res_valid,
    output mrrp_pkg::result_t res
);
    import mrrp_pkg::*;

    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  high_reg, high_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic [6:0]  count_reg, count_next;

    logic [15:0] crc_upd;
    logic [8:0]  crc_end;
    logic [8:0]  data_off;

    mrrp_crc_byte u_crc
    (
        .crc      (crc_reg),
        .data     (rx_byte),
        .crc_next (crc_upd)
    );

    assign crc_end  = HEADER_LEN + {1'b0, len_reg};
    assign data_off = pos_reg - HEADER_LEN;

    // Decode one byte: advance the frame state and form at most one result
    always_comb
    begin
        pos_next     = pos_reg;
        len_next     = len_reg;
        crc_next     = crc_reg;
        high_next    = high_reg;
        crc_low_next = crc_low_reg;
        count_next   = count_reg;
        res_valid    = 1'b0;
        res          = '0;

        if (frame_end)
        begin
            res_valid = 1'b1;
            res.kind  = KIND_STATUS;
            if ({1'b0, pos_reg} != LAST_OFFSET + {2'b00, len_reg})
            begin
                res.frame_status = STATUS_LENGTH;
            end
            else if ({rx_byte, crc_low_reg} == crc_reg)
            begin
                res.frame_status = STATUS_OK;
            end
            else
            begin
                res.frame_status = STATUS_CRC;
            end
            pos_next     = '0;
            len_next     = '0;
            crc_next     = CRC_INIT;
            high_next    = '0;
            crc_low_next = '0;
            count_next   = '0;
        end
        else
        begin
            if (pos_reg < crc_end)
            begin
                crc_next = crc_upd;
            end
            if (pos_reg == COUNT_POS)
            begin
                len_next = rx_byte;
            end
            if (pos_reg == crc_end)
            begin
                crc_low_next = rx_byte;
            end
            if (pos_reg >= HEADER_LEN)
            begin
                if (!data_off[0])
                begin
                    high_next = rx_byte;
                end
                else if (data_off <= {1'b0, len_reg})
                begin
                    res_valid       = 1'b1;
                    res.kind        = KIND_VALUE;
                    res.reg_value   = {high_reg, rx_byte};
                    res.value_index = count_reg;
                    count_next      = count_reg + 7'd1;
                end
            end
            // Hold at the top for overlong frames
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            len_reg     <= '0;
            crc_reg     <= CRC_INIT;
            high_reg    <= '0;
            crc_low_reg <= '0;
            count_reg   <= '0;
        end
        else if (step)
        begin
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            crc_reg     <= crc_next;
            high_reg    <= high_next;
            crc_low_reg <= crc_low_next;
            count_reg   <= count_next;
        end
    end

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step && frame_end |=> pos_reg == '0 && crc_reg == CRC_INIT && count_reg == '0)
        else $error("frame end did not restart the frame state");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == KIND_STATUS |-> res.reg_value == '0 && res.value_index == '0)
        else $error("status result carries value fields");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.frame_status == STATUS_OK || res.frame_status == STATUS_LENGTH
                      || res.frame_status == STATUS_CRC)
        else $error("undefined frame status code");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && res.kind == KIND_VALUE |=> count_reg == $past(count_reg) + 7'd1)
        else $error("value count did not advance with a value result");
endmodule

@@ rtl/modbus_read_response_parser.sv @@
// Modbus RTU read-holding-registers response parser. Feed one frame byte per
// beat and flag the last byte with frame_end. A new beat is accepted every
// cycle unless the result register is full and not being taken. Each result
// passes the input register, then the result register. Each big-endian
// register value comes out as soon as its second byte arrives; the last
// byte yields one status result (ok, length error or CRC mismatch). On a
// non-ok status, drop the values already delivered for that frame. Slave and
// function bytes are not checked.
module modbus_read_response_parser
(
    input  logic          clk,
    input  logic          rst_n,
    mrrp_byte_if.sink     frame_bytes,
    mrrp_result_if.source results
);
    import mrrp_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_data_reg;

    logic       s1_advance;
    logic       res_valid;
    result_t    res;

    // Advance the decoded byte when the result register is free or draining
    assign s1_advance        = s1_valid_reg && (!out_valid_reg || results.ready);
    assign frame_bytes.ready = !s1_valid_reg || s1_advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (frame_bytes.ready)
        begin
            s1_valid_reg <= frame_bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_bytes.ready && frame_bytes.valid)
        begin
            s1_byte_reg <= frame_bytes.rx_byte;
            s1_end_reg  <= frame_bytes.frame_end;
        end
    end

    mrrp_frame_tracker u_tracker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_advance),
        .rx_byte   (s1_byte_reg),
        .frame_end (s1_end_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register: load on advance, drop when taken
    always_comb
    begin
        if (s1_advance)
        begin
            out_valid_next = res_valid;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.kind         = out_data_reg.kind;
    assign results.reg_value    = out_data_reg.reg_value;
    assign results.value_index  = out_data_reg.value_index;
    assign results.frame_status = out_data_reg.frame_status;
endmodule
